[hw/rtl/ektc_pkg.sv]
// Shared types, constants and the character table for the encoder/keypad text cursor.
// Depends on nothing; every module in hw/rtl imports it, the two interfaces do not.
package ektc_pkg;

   localparam int TEXT_LEN_W = 16;
   localparam int CHAR_W     = 8;
   localparam int COL_W      = 5;
   localparam int ROW_W      = 2;
   localparam int KEY_IDX_W  = 7;
   localparam int KEY_COUNT  = 78;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [TEXT_LEN_W-1:0] text_pos_type;
   typedef logic [COL_W-1:0]      col_type;
   typedef logic [ROW_W-1:0]      row_type;
   typedef logic [CHAR_W-1:0]     char_type;

   // register word index, taken from paddr[2]
   localparam logic REG_TEXT_LENGTH = 1'b0;
   localparam text_pos_type TEXT_LENGTH_RESET = 16'd29;

   // encoder phase differences that count as a step
   localparam logic [1:0] STEP_FWD  = 2'd1;
   localparam logic [1:0] STEP_BACK = 2'd3;

   // grid geometry
   localparam col_type GRID_COLS   = 5'd26;
   localparam col_type LAST_COL    = 5'd25;
   localparam col_type SPECIAL_COL = 5'd26;
   localparam row_type ROW_LOWER   = 2'd0;
   localparam row_type ROW_SYM     = 2'd2;

   localparam char_type SPACE_CODE = 8'h20;

   // direction button levels or flags
   typedef struct packed {
      logic left;
      logic right;
      logic up;
      logic down;
   } btn_type;

   // selected grid cell
   typedef struct packed {
      col_type col;
      row_type row;
   } grid_pos_type;

   // accepted scan tick held in the input register
   typedef struct packed {
      logic    enc_a_pin;
      logic    enc_b_pin;
      btn_type dir_pins;
      logic    center_pin;
   } req_item_type;

   // result held in the output register
   typedef struct packed {
      logic         write_valid;
      char_type     write_char;
      text_pos_type write_pos;
      logic         edit_done;
      text_pos_type caret_now;
      col_type      grid_col;
      row_type      grid_row;
   } rsp_item_type;

   // lower case, upper case, then digits and symbols, 26 per row
   localparam char_type KEY_ROM [KEY_COUNT] = '{
      8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d,
      8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a,
      8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d,
      8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h20, 8'h21, 8'h2c,
      8'h2e, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28, 8'h29, 8'h2d, 8'h2b, 8'h3d, 8'h5f, 8'h3f
   };

   // look up the character of an ordinary grid cell (row 0..2, column 0..25)
   function automatic char_type key_char(input row_type row, input col_type col);
      logic [KEY_IDX_W-1:0] idx;
      idx = KEY_IDX_W'({5'b0, row} * KEY_IDX_W'(GRID_COLS)) + KEY_IDX_W'(col);
      return KEY_ROM[idx];
   endfunction

endpackage

[hw/rtl/ektc_req_if.sv]
// Input channel: one scan tick of encoder and button levels with valid/ready.
// Depends on nothing.
interface ektc_req_if;
   logic valid;
   logic ready;
   logic enc_a_pin;
   logic enc_b_pin;
   logic left_pin;
   logic right_pin;
   logic up_pin;
   logic down_pin;
   logic center_pin;

   modport source (
      output valid, enc_a_pin, enc_b_pin, left_pin, right_pin, up_pin, down_pin, center_pin,
      input  ready
   );
   modport sink (
      input  valid, enc_a_pin, enc_b_pin, left_pin, right_pin, up_pin, down_pin, center_pin,
      output ready
   );
endinterface

[hw/rtl/ektc_rsp_if.sv]
// Result channel: write request, save flag, caret and grid selection with valid/ready.
// Depends on nothing.
interface ektc_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_valid;
   logic [7:0]  write_char;
   logic [15:0] write_pos;
   logic        edit_done;
   logic [15:0] caret_now;
   logic [4:0]  grid_col;
   logic [1:0]  grid_row;

   modport source (
      output valid, write_valid, write_char, write_pos, edit_done, caret_now, grid_col,
             grid_row,
      input  ready
   );
   modport sink (
      input  valid, write_valid, write_char, write_pos, edit_done, caret_now, grid_col,
             grid_row,
      output ready
   );
endinterface

[hw/rtl/encoder_keypad_text_cursor.sv]
// Encoder and keypad text cursor: takes one scan tick per cycle while the result channel is not
// stalled, and returns one result per tick through the input register, then the result register; the
// caret, button and grid updates for a tick are one pass of logic between those registers.
// Depends on ektc_pkg, ektc_req_if, ektc_rsp_if, ektc_caret and ektc_select.
module encoder_keypad_text_cursor (
   input  logic                                  clock,
   input  logic                                  reset,
   ektc_req_if.sink                              req_bus,
   ektc_rsp_if.source                            rsp_bus,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ektc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [ektc_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [ektc_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);
   import ektc_pkg::*;

   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_item_ff, out_item_in;
   logic          advance;
   text_pos_type  text_length_ff;
   text_pos_type  caret_next;
   grid_pos_type  pos_next;

   // register file
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_TEXT_LENGTH) ?
                   {{(CSR_DATA_W-TEXT_LEN_W){1'b0}}, text_length_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_length_ff <= TEXT_LENGTH_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_LENGTH) begin
         text_length_ff <= pwdata[TEXT_LEN_W-1:0];
      end
   end

   // move a tick on when the result register is free or being drained
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign in_valid_in   = req_bus.ready ? req_bus.valid : in_valid_ff;
   assign out_valid_in  = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   ektc_caret u_caret (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .enc_a_pin   (in_item_ff.enc_a_pin),
      .enc_b_pin   (in_item_ff.enc_b_pin),
      .text_length (text_length_ff),
      .caret_next  (caret_next)
   );

   ektc_select u_select (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .dir_pins (in_item_ff.dir_pins),
      .pos_next (pos_next)
   );

   // form the write or save for a held centre button
   always_comb begin
      out_item_in             = '0;
      out_item_in.caret_now   = caret_next;
      out_item_in.grid_col    = pos_next.col;
      out_item_in.grid_row    = pos_next.row;
      if (!in_item_ff.center_pin) begin
         if (pos_next.col >= SPECIAL_COL) begin
            if (pos_next.row == ROW_LOWER) begin
               out_item_in.write_valid = 1'b1;
               out_item_in.write_char  = SPACE_CODE;
               out_item_in.write_pos   = caret_next;
            end else if (pos_next.row == ROW_SYM) begin
               out_item_in.edit_done = 1'b1;
            end
         end else if (pos_next.row <= ROW_SYM) begin
            out_item_in.write_valid = 1'b1;
            out_item_in.write_char  = key_char(pos_next.row, pos_next.col);
            out_item_in.write_pos   = caret_next;
         end
      end
   end

   // handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff.enc_a_pin      <= req_bus.enc_a_pin;
         in_item_ff.enc_b_pin      <= req_bus.enc_b_pin;
         in_item_ff.dir_pins.left  <= req_bus.left_pin;
         in_item_ff.dir_pins.right <= req_bus.right_pin;
         in_item_ff.dir_pins.up    <= req_bus.up_pin;
         in_item_ff.dir_pins.down  <= req_bus.down_pin;
         in_item_ff.center_pin     <= req_bus.center_pin;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.write_valid = out_item_ff.write_valid;
   assign rsp_bus.write_char  = out_item_ff.write_char;
   assign rsp_bus.write_pos   = out_item_ff.write_pos;
   assign rsp_bus.edit_done   = out_item_ff.edit_done;
   assign rsp_bus.caret_now   = out_item_ff.caret_now;
   assign rsp_bus.grid_col    = out_item_ff.grid_col;
   assign rsp_bus.grid_row    = out_item_ff.grid_row;

   // a result never both writes and saves
   a_write_or_done: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.write_valid && rsp_bus.edit_done))
      else $error("write and save reported in the same result");

   // selection stays inside the grid plus the special column
   a_grid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.grid_col <= SPECIAL_COL && rsp_bus.grid_row <= ROW_SYM))
      else $error("grid selection out of range");

   // an empty input register always takes a transfer
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_bus.ready)
      else $error("input stalled while empty");

   // a tick waiting behind a full, stalled result register is held
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_bus.ready) |=> in_valid_ff)
      else $error("stalled tick dropped");

endmodule

[hw/rtl/ektc_caret.sv]
// Quadrature decoder and bounded text caret.
// Depends on ektc_pkg.
module ektc_caret (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  enc_a_pin,
   input  logic                  enc_b_pin,
   input  ektc_pkg::text_pos_type text_length,
   output ektc_pkg::text_pos_type caret_next
);
   import ektc_pkg::*;

   logic [1:0]   last_phase_ff, last_phase_in;
   text_pos_type caret_ff, caret_in;
   logic [1:0]   phase;
   logic [1:0]   diff;

   // Gray-decode the pins: A gives 3, B toggles bit 0
   assign phase = {enc_a_pin, enc_a_pin ^ enc_b_pin};
   assign diff  = last_phase_ff - phase;

   // step the caret on an odd phase difference, hold on none or a skipped step
   always_comb begin
      caret_in      = caret_ff;
      last_phase_in = last_phase_ff;
      case (diff)
         STEP_FWD: begin
            if ({1'b0, caret_ff} + 17'd1 < {1'b0, text_length}) begin
               caret_in = caret_ff + 16'd1;
            end
            last_phase_in = phase;
         end
         STEP_BACK: begin
            if (caret_ff != '0) begin
               caret_in = caret_ff - 16'd1;
            end
            last_phase_in = phase;
         end
         default: begin
            caret_in      = caret_ff;
            last_phase_in = last_phase_ff;
         end
      endcase
   end

   assign caret_next = caret_in;

   // commit when the tick moves on to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= '0;
         caret_ff      <= '0;
      end else if (advance) begin
         last_phase_ff <= last_phase_in;
         caret_ff      <= caret_in;
      end
   end

endmodule

[hw/rtl/ektc_select.sv]
// Press-qualified direction buttons and the grid selection they move.
// Depends on ektc_pkg.
module ektc_select (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ektc_pkg::btn_type      dir_pins,
   output ektc_pkg::grid_pos_type pos_next
);
   import ektc_pkg::*;

   btn_type held_ff, held_in;
   btn_type fire;
   col_type col_ff;
   row_type row_ff;
   col_type col_in;
   row_type row_in;

   // fire once per press, re-arm on release
   assign held_in = ~dir_pins;
   assign fire    = held_in & ~held_ff;

   // apply left, right, up, down in that order
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (fire.left && col_in != '0) begin
         col_in = col_in - 5'd1;
      end
      if (fire.right) begin
         if (col_in == LAST_COL) begin
            if (row_in != ROW_SYM) begin
               row_in = ROW_LOWER;
            end
            col_in = SPECIAL_COL;
         end else if (col_in < LAST_COL) begin
            col_in = col_in + 5'd1;
         end
      end
      if (fire.up) begin
         if (col_in == SPECIAL_COL && row_in == ROW_SYM) begin
            row_in = ROW_LOWER;
         end else if (row_in != ROW_LOWER) begin
            row_in = row_in - 2'd1;
         end
      end
      if (fire.down) begin
         if (col_in == SPECIAL_COL && row_in == ROW_LOWER) begin
            row_in = ROW_SYM;
         end else if (row_in < ROW_SYM) begin
            row_in = row_in + 2'd1;
         end
      end
   end

   assign pos_next.col = col_in;
   assign pos_next.row = row_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         col_ff  <= '0;
         row_ff  <= ROW_SYM;
      end else if (advance) begin
         held_ff <= held_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule
